[hw/rtl/rged_pkg.sv]
package rged_pkg;

  // Channel lanes and per-lane error word
  localparam int LANES      = 3;
  localparam int PIX_W      = 8;
  localparam int ERR_W      = 14;
  localparam int LINE_W     = LANES * ERR_W;

  // Configuration registers
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 11;
  localparam int IMG_W_W    = 11;
  localparam int THR_W      = 8;

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD   = 1'd1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 11'd256;
  localparam logic [THR_W-1:0]   THRESHOLD_RST   = 8'd127;

  // Stream payload widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam int MAX_WIDTH_DEF = 1024;

  // Per-lane result handed to the merge stage
  typedef struct packed {
    logic                    dither;
    logic                    plain;
    logic signed [ERR_W-1:0] below_left;
    logic signed [ERR_W-1:0] below;
  } lane_res_t;

endpackage

[hw/rtl/rged_lane.sv]
module rged_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           frame_start,
  input  logic                           row_end,
  input  logic [rged_pkg::PIX_W-1:0]     pix,
  input  logic signed [rged_pkg::ERR_W-1:0] above,
  input  logic [rged_pkg::THR_W-1:0]     thr,
  output rged_pkg::lane_res_t            res
);
  import rged_pkg::*;

  logic signed [ERR_W-1:0] right_r, right_nxt;
  logic signed [ERR_W-1:0] bp_r, bp_nxt;
  logic signed [ERR_W-1:0] brp_r, brp_nxt;

  logic signed [ERR_W-1:0] right_eff, bp_eff, brp_eff;
  logic signed [15:0]      total, rnd;
  logic signed [11:0]      adj, err;
  logic                    bit_q;
  logic signed [ERR_W-1:0] e1, e3, e5, e7;

  // Drop carried error at a frame start
  assign right_eff = frame_start ? '0 : right_r;
  assign bp_eff    = frame_start ? '0 : bp_r;
  assign brp_eff   = frame_start ? '0 : brp_r;

  // Adjusted value, truncated toward zero, then quantize
  always_comb begin
    total = $signed({4'b0000, pix, 4'b0000})
          + $signed({{2{above[ERR_W-1]}}, above})
          + $signed({{2{right_eff[ERR_W-1]}}, right_eff});
    rnd   = total + (total[15] ? 16'sd15 : 16'sd0);
    adj   = rnd[15:4];
    bit_q = adj > $signed({4'b0000, thr});
    err   = bit_q ? adj - 12'sd255 : adj;
    e1    = {{(ERR_W-12){err[11]}}, err};
    e3    = e1 + (e1 <<< 1);
    e5    = e1 + (e1 <<< 2);
    e7    = (e1 <<< 3) - e1;
  end

  assign res.dither     = bit_q;
  assign res.plain      = pix > thr;
  assign res.below_left = bp_eff + e3;
  assign res.below      = brp_eff + e5;

  // Advance the error pipeline; clear at row end
  always_comb begin
    right_nxt = right_r;
    bp_nxt    = bp_r;
    brp_nxt   = brp_r;
    if (accept) begin
      if (row_end) begin
        right_nxt = '0;
        bp_nxt    = '0;
        brp_nxt   = '0;
      end else begin
        right_nxt = e7;
        bp_nxt    = res.below;
        brp_nxt   = e1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r <= '0;
      bp_r    <= '0;
      brp_r   <= '0;
    end else begin
      right_r <= right_nxt;
      bp_r    <= bp_nxt;
      brp_r   <= brp_nxt;
    end
  end

endmodule

[hw/rtl/rged_line_buf.sv]
module rged_line_buf #(
  parameter int DEPTH = rged_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(rged_pkg::MAX_WIDTH_DEF)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rged_pkg::LINE_W-1:0]  wr_data,
  output logic [rged_pkg::LINE_W-1:0]  rd_data
);
  import rged_pkg::*;

  logic [LINE_W-1:0] mem [DEPTH];
  logic [LINE_W-1:0] mem_q_r;
  logic [LINE_W-1:0] byp_r, byp_nxt;
  logic              byp_vld_r, byp_vld_nxt;
  logic [AW-1:0]     addr_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, one pixel ahead
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      addr_r  <= rd_addr;
    end
  end

  // Track writes that land on the entry already fetched
  always_comb begin
    byp_vld_nxt = byp_vld_r;
    byp_nxt     = byp_r;
    if (rd_en) begin
      byp_vld_nxt = wr_en && (wr_addr == rd_addr);
      byp_nxt     = wr_data;
    end else if (wr_en && (wr_addr == addr_r)) begin
      byp_vld_nxt = 1'b1;
      byp_nxt     = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else begin
      byp_vld_r <= byp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_r <= byp_nxt;
  end

  assign rd_data = byp_vld_r ? byp_r : mem_q_r;

endmodule

[hw/rtl/rgb_error_diffusion_dither.sv]
// Channel  | Direction | Ports               | Beat contents
// in_      | slave     | tvalid/tready/tdata | one RGB pixel, tuser = frame start
//                      | tuser               |
// out_     | master    | tvalid/tready/tdata | six 1-bit results for that pixel
// cfg_     | write     | wr_en/addr/wr_data  | image width, threshold
//
// One pixel per clock when not stalled; one registered result beat per pixel.
// The rate is set by the right-neighbor error loop, closed through one register
// per lane, and by the line buffer: one read (issued a pixel ahead) and one write
// a cycle; a row's last-column write goes out the next cycle unless at column 0.
// rst_n is synchronous; the line buffer needs no clearing pass after reset.
// A stalled result beat holds and blocks input; a pixel enters as it leaves.
module rgb_error_diffusion_dither #(
  parameter int MAX_WIDTH = rged_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic [rged_pkg::IN_TDATA_W-1:0]     in_tdata,
  // frame_start[0]
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // dither_red[0], dither_green[1], dither_blue[2],
  // plain_red[3], plain_green[4], plain_blue[5], zero[7:6]
  output logic [rged_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [rged_pkg::CFG_AW-1:0]         cfg_addr,
  input  logic [rged_pkg::CFG_DW-1:0]         cfg_wr_data
);
  import rged_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

  logic [IMG_W_W-1:0] img_w_r;
  logic [THR_W-1:0]   thr_r;

  logic [CW-1:0]      col_r, col_nxt, col_eff, col_inc;
  logic               first_row_r, first_row_nxt, first_eff;
  logic [EW-1:0]      width_x, width_eff, col_plus;
  logic               accept, row_end, fs;

  logic               tail_vld_r;
  logic [CW-1:0]      tail_addr_r;
  logic [LINE_W-1:0]  tail_data_r;

  logic               wr_en;
  logic [CW-1:0]      wr_addr;
  logic [LINE_W-1:0]  wr_data, above_word, pix_wr_word, tail_word;
  logic [LINE_W-1:0]  rd_word;

  lane_res_t          res [LANES];
  logic [LANES-1:0]   dith, plain;

  logic               out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMAGE_WIDTH_RST;
      thr_r   <= THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_IMAGE_WIDTH: img_w_r <= cfg_wr_data[IMG_W_W-1:0];
        REG_THRESHOLD:   thr_r   <= cfg_wr_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign fs        = in_tuser;

  // Column position and row end
  always_comb begin
    width_x   = EW'(img_w_r);
    if (width_x == '0) begin
      width_eff = EW'(1);
    end else if (width_x > MAX_W) begin
      width_eff = MAX_W;
    end else begin
      width_eff = width_x;
    end
    col_eff   = fs ? '0 : col_r;
    first_eff = fs || first_row_r;
    col_inc   = col_eff + CW'(1);
    col_plus  = EW'(col_eff) + EW'(1);
    row_end   = col_plus >= width_eff;
  end

  always_comb begin
    col_nxt       = col_r;
    first_row_nxt = first_row_r;
    if (accept) begin
      col_nxt       = row_end ? '0 : col_inc;
      first_row_nxt = row_end ? 1'b0 : first_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
      tail_vld_r  <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
      tail_vld_r  <= accept && row_end && (col_eff != '0);
    end
  end

  // Channel lanes
  assign above_word = first_eff ? '0 : rd_word;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    rged_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .accept      (accept),
      .frame_start (fs),
      .row_end     (row_end),
      .pix         (in_tdata[PIX_W*i +: PIX_W]),
      .above       (above_word[ERR_W*i +: ERR_W]),
      .thr         (thr_r),
      .res         (res[i])
    );
    assign dith[i]                      = res[i].dither;
    assign plain[i]                     = res[i].plain;
    assign pix_wr_word[ERR_W*i +: ERR_W] = res[i].below_left;
    assign tail_word[ERR_W*i +: ERR_W]   = res[i].below;
  end

  // Merge lanes into line buffer writes; last column is registered, written next cycle
  always_ff @(posedge clk) begin
    if (accept && row_end) begin
      tail_addr_r <= col_eff;
      tail_data_r <= tail_word;
    end
  end

  always_comb begin
    if (tail_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = tail_addr_r;
      wr_data = tail_data_r;
    end else if (accept && row_end && (col_eff == '0)) begin
      // one-column row: the down entry is the only write, send it now
      wr_en   = 1'b1;
      wr_addr = col_eff;
      wr_data = tail_word;
    end else begin
      wr_en   = accept && (col_eff != '0);
      wr_addr = col_eff - CW'(1);
      wr_data = pix_wr_word;
    end
  end

  rged_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col_nxt),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_word)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {2'b00, plain, dith};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[hw/rtl/rged_checker.sv]
module rged_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic [rged_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [rged_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready
);
  import rged_pkg::*;

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Every accepted pixel yields a result beat next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted pixel produced no result");

  // Input opens whenever the output register frees up
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not track output register");

  // First pixel of a frame carries no error: dithered equals plain
  a_frame_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> out_tdata[2:0] == out_tdata[5:3])
    else $error("frame start pixel picked up stale error");

  // Pad bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:6] == 2'b00)
    else $error("result pad bits not zero");

endmodule

bind rgb_error_diffusion_dither rged_checker u_rged_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
